/* hdl/ile_pkg.sv */
// Shared constants, codes and types for the indexed list engine.
// No dependencies; imported by the top level.
package ile_pkg;

    // Storage geometry
    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // Transaction field widths
    localparam int FUNC_BITS   = 4;
    localparam int POS_BITS    = 7;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;

    // Stream packing, rounded up to whole bytes
    localparam int S_FIELD_BITS = FUNC_BITS + 2 * POS_BITS + VALUE_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = STATUS_BITS + 3 * VALUE_BITS + POS_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    // Operation codes
    localparam logic [FUNC_BITS-1:0] FN_PUSH_FRONT = 4'd0;
    localparam logic [FUNC_BITS-1:0] FN_PUSH_BACK  = 4'd1;
    localparam logic [FUNC_BITS-1:0] FN_POP_FRONT  = 4'd2;
    localparam logic [FUNC_BITS-1:0] FN_POP_BACK   = 4'd3;
    localparam logic [FUNC_BITS-1:0] FN_READ       = 4'd4;
    localparam logic [FUNC_BITS-1:0] FN_INSERT     = 4'd5;
    localparam logic [FUNC_BITS-1:0] FN_REMOVE     = 4'd6;
    localparam logic [FUNC_BITS-1:0] FN_ERASE      = 4'd7;
    localparam logic [FUNC_BITS-1:0] FN_CLEAR      = 4'd8;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_WAIT,
        ST_MV_RD,
        ST_MV_WR,
        ST_PUT,
        ST_FETCH_F,
        ST_FETCH_B,
        ST_FETCH_D,
        ST_DONE
    } state_t;

endpackage

/* hdl/ile_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used by the indexed list engine for word storage.
module ile_ram #(
    parameter int RAM_WIDTH = 32,
    parameter int RAM_DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [$clog2(RAM_DEPTH)-1:0] wr_addr,
    input  logic [RAM_WIDTH-1:0]         wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(RAM_DEPTH)-1:0] rd_addr,
    output logic [RAM_WIDTH-1:0]         rd_data
);

    logic [RAM_WIDTH-1:0] mem [RAM_DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/indexed_list_engine.sv */
// Indexed list engine: bounded ordered list with push/pop/read/insert/remove/erase/clear.
// Each transaction is decoded, then shifts N stored words (N = 0..DEPTH-1) in a move loop
// that reads and then writes one stored word per pass through the RAM, then fetches front and back.
// Throughput: one transaction at a time; input is taken again once the result is registered.
// Reset (aresetn low, synchronous) empties the list and drops any pending result.
// Depends on ile_pkg and ile_ram.
module indexed_list_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [3:0] func, [10:4] index, [17:11] end_index, [49:18] value, rest zero
    input  logic [ile_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] status, [33:2] read_value, [40:34] count, [72:41] front_value,
    // [104:73] back_value, rest zero
    output logic [ile_pkg::M_TDATA_BITS-1:0] m_axis_tdata
);
    import ile_pkg::*;

    state_t                 state_reg, state_next;
    logic [FUNC_BITS-1:0]   func_reg, func_next;
    logic [POS_BITS-1:0]    idx_reg, idx_next;
    logic [POS_BITS-1:0]    endi_reg, endi_next;
    logic [WORD_BITS-1:0]   val_reg, val_next;
    logic [CNT_BITS-1:0]    held_reg, held_next;
    status_t                status_reg, status_next;
    logic [WORD_BITS-1:0]   rd_reg, rd_next;
    logic [WORD_BITS-1:0]   front_reg, front_next;
    logic [WORD_BITS-1:0]   back_reg, back_next;
    logic [ADDR_BITS-1:0]   src_reg, src_next;
    logic [ADDR_BITS-1:0]   dst_reg, dst_next;
    logic [CNT_BITS-1:0]    left_reg, left_next;
    logic                   up_reg, up_next;
    logic                   put_reg, put_next;
    logic [ADDR_BITS-1:0]   put_addr_reg, put_addr_next;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [WORD_BITS-1:0]   out_rd_reg, out_rd_next;
    logic [CNT_BITS-1:0]    out_count_reg, out_count_next;
    logic [WORD_BITS-1:0]   out_front_reg, out_front_next;
    logic [WORD_BITS-1:0]   out_back_reg, out_back_next;

    // Decode plan
    status_t                dec_status;
    logic [CNT_BITS-1:0]    dec_held;
    logic [CNT_BITS-1:0]    dec_left;
    logic [ADDR_BITS-1:0]   dec_src, dec_dst;
    logic                   dec_up, dec_put, dec_read, dec_wr;
    logic [ADDR_BITS-1:0]   dec_put_addr;

    // RAM port
    logic                   ram_wr_en, ram_rd_en;
    logic [ADDR_BITS-1:0]   ram_wr_addr, ram_rd_addr;
    logic [WORD_BITS-1:0]   ram_wr_data, ram_rd_data;

    logic                   s_fire, out_load;

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    ile_ram #(
        .RAM_WIDTH (WORD_BITS),
        .RAM_DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Work out status, new count and the shift plan for the latched transaction
    always_comb begin
        dec_status   = STAT_OK;
        dec_held     = held_reg;
        dec_left     = '0;
        dec_src      = '0;
        dec_dst      = '0;
        dec_up       = 1'b0;
        dec_put      = 1'b0;
        dec_read     = 1'b0;
        dec_wr       = 1'b0;
        dec_put_addr = '0;
        case (func_reg)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (held_reg >= CNT_BITS'(DEPTH)) begin
                    dec_status = STAT_FULL;
                end else begin
                    dec_held = held_reg + CNT_BITS'(1);
                    if (func_reg == FN_PUSH_FRONT) begin
                        dec_up       = 1'b1;
                        dec_left     = held_reg;
                        dec_src      = ADDR_BITS'(held_reg) - ADDR_BITS'(1);
                        dec_dst      = ADDR_BITS'(held_reg);
                        dec_put      = 1'b1;
                        dec_put_addr = '0;
                    end else begin
                        dec_wr = 1'b1;
                    end
                end
            end
            FN_POP_FRONT: begin
                if (held_reg == '0) begin
                    dec_status = STAT_EMPTY;
                end else begin
                    dec_held = held_reg - CNT_BITS'(1);
                    dec_left = held_reg - CNT_BITS'(1);
                    dec_src  = ADDR_BITS'(1);
                    dec_dst  = '0;
                end
            end
            FN_POP_BACK: begin
                if (held_reg == '0) begin
                    dec_status = STAT_EMPTY;
                end else begin
                    dec_held = held_reg - CNT_BITS'(1);
                end
            end
            FN_READ: begin
                if (idx_reg >= held_reg) begin
                    dec_status = STAT_RANGE;
                end else begin
                    dec_read = 1'b1;
                end
            end
            FN_INSERT: begin
                if (idx_reg > held_reg) begin
                    dec_status = STAT_RANGE;
                end else if (held_reg >= CNT_BITS'(DEPTH)) begin
                    dec_status = STAT_FULL;
                end else begin
                    dec_held     = held_reg + CNT_BITS'(1);
                    dec_up       = 1'b1;
                    dec_left     = held_reg - CNT_BITS'(idx_reg);
                    dec_src      = ADDR_BITS'(held_reg) - ADDR_BITS'(1);
                    dec_dst      = ADDR_BITS'(held_reg);
                    dec_put      = 1'b1;
                    dec_put_addr = ADDR_BITS'(idx_reg);
                end
            end
            FN_REMOVE: begin
                if (idx_reg >= held_reg) begin
                    dec_status = STAT_RANGE;
                end else begin
                    dec_held = held_reg - CNT_BITS'(1);
                    dec_left = held_reg - CNT_BITS'(idx_reg) - CNT_BITS'(1);
                    dec_src  = ADDR_BITS'(idx_reg) + ADDR_BITS'(1);
                    dec_dst  = ADDR_BITS'(idx_reg);
                end
            end
            FN_ERASE: begin
                if (idx_reg < held_reg && endi_reg <= held_reg && idx_reg < endi_reg) begin
                    dec_held = held_reg - CNT_BITS'(endi_reg) + CNT_BITS'(idx_reg);
                    dec_left = held_reg - CNT_BITS'(endi_reg);
                    dec_src  = ADDR_BITS'(endi_reg);
                    dec_dst  = ADDR_BITS'(idx_reg);
                end
            end
            FN_CLEAR: begin
                dec_held = '0;
            end
            default: begin
                dec_status = STAT_OK;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (dec_read) begin
                    state_next = ST_RD_WAIT;
                end else if (dec_left != '0) begin
                    state_next = ST_MV_RD;
                end else if (dec_put) begin
                    state_next = ST_PUT;
                end else begin
                    state_next = ST_FETCH_F;
                end
            end
            ST_RD_WAIT: state_next = ST_FETCH_F;
            ST_MV_RD:   state_next = ST_MV_WR;
            ST_MV_WR: begin
                if (left_reg == CNT_BITS'(1)) begin
                    state_next = put_reg ? ST_PUT : ST_FETCH_F;
                end else begin
                    state_next = ST_MV_RD;
                end
            end
            ST_PUT:     state_next = ST_FETCH_F;
            ST_FETCH_F: state_next = (held_reg == '0) ? ST_DONE : ST_FETCH_B;
            ST_FETCH_B: state_next = ST_FETCH_D;
            ST_FETCH_D: state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and RAM control per state
    always_comb begin
        func_next       = func_reg;
        idx_next        = idx_reg;
        endi_next       = endi_reg;
        val_next        = val_reg;
        held_next       = held_reg;
        status_next     = status_reg;
        rd_next         = rd_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        left_next       = left_reg;
        up_next         = up_reg;
        put_next        = put_reg;
        put_addr_next   = put_addr_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = dst_reg;
        ram_wr_data     = ram_rd_data;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = src_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_rd_next     = out_rd_reg;
        out_count_next  = out_count_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;

        // Drop the result once the sink takes it
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                // Latch the incoming transaction
                if (s_fire) begin
                    func_next = s_axis_tdata[FUNC_BITS-1:0];
                    idx_next  = s_axis_tdata[FUNC_BITS +: POS_BITS];
                    endi_next = s_axis_tdata[FUNC_BITS+POS_BITS +: POS_BITS];
                    val_next  = WORD_BITS'(s_axis_tdata[FUNC_BITS+2*POS_BITS +: VALUE_BITS]);
                end
            end
            ST_DECODE: begin
                status_next   = dec_status;
                held_next     = dec_held;
                rd_next       = '0;
                src_next      = dec_src;
                dst_next      = dec_dst;
                left_next     = dec_left;
                up_next       = dec_up;
                put_next      = dec_put;
                put_addr_next = dec_put_addr;
                // Append at the back directly
                ram_wr_en     = dec_wr;
                ram_wr_addr   = ADDR_BITS'(held_reg);
                ram_wr_data   = val_reg;
                // Read a single position
                ram_rd_en     = dec_read;
                ram_rd_addr   = ADDR_BITS'(idx_reg);
            end
            ST_RD_WAIT: begin
                rd_next = ram_rd_data;
            end
            ST_MV_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = src_reg;
            end
            ST_MV_WR: begin
                // Copy one word, then advance both pointers
                ram_wr_en   = 1'b1;
                ram_wr_addr = dst_reg;
                ram_wr_data = ram_rd_data;
                left_next   = left_reg - CNT_BITS'(1);
                if (up_reg) begin
                    src_next = src_reg - ADDR_BITS'(1);
                    dst_next = dst_reg - ADDR_BITS'(1);
                end else begin
                    src_next = src_reg + ADDR_BITS'(1);
                    dst_next = dst_reg + ADDR_BITS'(1);
                end
            end
            ST_PUT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = put_addr_reg;
                ram_wr_data = val_reg;
            end
            ST_FETCH_F: begin
                ram_rd_en   = (held_reg != '0);
                ram_rd_addr = '0;
                front_next  = '0;
                back_next   = '0;
            end
            ST_FETCH_B: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ADDR_BITS'(held_reg - CNT_BITS'(1));
                front_next  = ram_rd_data;
            end
            ST_FETCH_D: begin
                back_next = ram_rd_data;
            end
            ST_DONE: begin
                // Hand the result to the output register
                if (out_load) begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_rd_next     = rd_reg;
                    out_count_next  = held_reg;
                    out_front_next  = front_reg;
                    out_back_next   = back_reg;
                end
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        idx_reg        <= idx_next;
        endi_reg       <= endi_next;
        val_reg        <= val_next;
        status_reg     <= status_next;
        rd_reg         <= rd_next;
        front_reg      <= front_next;
        back_reg       <= back_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        left_reg       <= left_next;
        up_reg         <= up_next;
        put_reg        <= put_next;
        put_addr_reg   <= put_addr_next;
        out_status_reg <= out_status_next;
        out_rd_reg     <= out_rd_next;
        out_count_reg  <= out_count_next;
        out_front_reg  <= out_front_next;
        out_back_reg   <= out_back_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (M_TDATA_BITS - M_FIELD_BITS)'(0),
        VALUE_BITS'(out_back_reg),
        VALUE_BITS'(out_front_reg),
        POS_BITS'(out_count_reg),
        VALUE_BITS'(out_rd_reg),
        out_status_reg
    };

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_BITS'(DEPTH))
        else $error("list count exceeds capacity");

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == ST_DECODE)
        else $error("accepted transaction not decoded next cycle");

    a_move_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MV_RD || state_reg == ST_MV_WR) |-> left_reg != '0)
        else $error("shift loop running with no words left");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == STAT_FULL) |-> out_count_reg == CNT_BITS'(DEPTH))
        else $error("full status reported on a list that is not full");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == STAT_EMPTY) |-> out_count_reg == '0)
        else $error("empty status reported on a list that holds words");
`endif

endmodule
